/* rtl/core/dotr_pkg.sv */
// shared types and codes for the deadline-ordered task release block
package dotr_pkg;

  // operation codes of an input transaction
  localparam logic OP_SCHEDULE = 1'b0;
  localparam logic OP_TICK     = 1'b1;

  // result kinds
  localparam logic KIND_DUE    = 1'b0;
  localparam logic KIND_REJECT = 1'b1;

  // configuration register index bit (register 0 is halted)
  localparam logic REG_HALTED = 1'b0;

  // fixed payload widths
  localparam int HANDLE_BITS = 16;
  localparam int FIELD_TIME_BITS = 48;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PAST,
    ST_DRAIN,
    ST_HEAD
  } state_t;

  // per-cycle command broadcast along the chain
  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_INSERT,
    CMD_SHIFT
  } cmd_t;

  typedef struct packed {
    cmd_t                   cmd;
    logic [HANDLE_BITS-1:0] ins_handle;
  } cell_ctl_t;

endpackage

/* rtl/core/deadline_ordered_task_release.sv */
// Deadline-ordered task release: pending handles sit in a chain of cells sorted by start
// time, head first. Each transaction is latched on acceptance and then worked on alone:
// every due release pops the head, an insert has all cells compare against the new time
// at once, and a reject or an immediate release is emitted on its own. A stalled result
// channel holds back every release and reject. No clearing pass is needed after reset.
module deadline_ordered_task_release #(
  parameter int QUEUE_DEPTH = 16,
  parameter int TIME_BITS   = 48
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_operation,
  input  logic [dotr_pkg::HANDLE_BITS-1:0] in_task_handle,
  input  logic [47:0]                      in_start_time,
  input  logic [47:0]                      in_current_time,
  // result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [dotr_pkg::HANDLE_BITS-1:0] out_released_handle,
  output logic                             out_result_kind,
  output logic                             out_last,
  // configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [2:0]                       paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  localparam int TW = (TIME_BITS < dotr_pkg::FIELD_TIME_BITS) ?
                      TIME_BITS : dotr_pkg::FIELD_TIME_BITS;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  dotr_pkg::state_t state_r, state_nxt;

  logic                             halted_r;
  logic [CW-1:0]                    count_r, count_nxt;
  logic                             op_r;
  logic [dotr_pkg::HANDLE_BITS-1:0] handle_r;
  logic [TW-1:0]                    start_r, now_r;

  logic                             out_valid_r;
  logic [dotr_pkg::HANDLE_BITS-1:0] out_handle_r;
  logic                             out_kind_r, out_last_r;

  logic                             accept, out_ld;
  logic                             emit, e_kind, e_last;
  logic [dotr_pkg::HANDLE_BITS-1:0] e_handle;
  logic                             head_due, next_due, full;
  dotr_pkg::cell_ctl_t              ctl;
  logic [TW-1:0]                    head_time, next_time;
  logic [dotr_pkg::HANDLE_BITS-1:0] head_handle;

  // configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == dotr_pkg::REG_HALTED) ? {31'b0, halted_r} : 32'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      halted_r <= 1'b0;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == dotr_pkg::REG_HALTED)) begin
      halted_r <= pwdata[0];
    end
  end

  // handshake
  assign in_stall = (state_r != dotr_pkg::ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_ld   = !out_valid_r || !out_stall;

  // latched transaction
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= in_operation;
      handle_r <= in_task_handle;
      start_r  <= in_start_time[TW-1:0];
      now_r    <= in_current_time[TW-1:0];
    end
  end

  // sorted chain
  dotr_chain #(.DEPTH(QUEUE_DEPTH), .TW(TW), .CW(CW)) u_chain (
    .clk         (clk),
    .ctl         (ctl),
    .ins_time    (start_r),
    .count       (count_r),
    .head_time   (head_time),
    .head_handle (head_handle),
    .next_time   (next_time)
  );

  // status of the chain head
  assign head_due = (count_r != '0) && (head_time <= now_r);
  assign next_due = (count_r > CW'(1)) && (next_time <= now_r);
  assign full     = (count_r == CW'(QUEUE_DEPTH));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dotr_pkg::ST_IDLE: begin
        if (accept && !halted_r) begin
          if ((in_operation == dotr_pkg::OP_SCHEDULE) &&
              (in_start_time[TW-1:0] < in_current_time[TW-1:0])) begin
            state_nxt = dotr_pkg::ST_PAST;
          end else begin
            state_nxt = dotr_pkg::ST_DRAIN;
          end
        end
      end
      dotr_pkg::ST_PAST: begin
        if (out_ld) state_nxt = dotr_pkg::ST_IDLE;
      end
      dotr_pkg::ST_DRAIN: begin
        if (head_due) begin
          state_nxt = dotr_pkg::ST_DRAIN;
        end else if (op_r == dotr_pkg::OP_TICK) begin
          state_nxt = dotr_pkg::ST_IDLE;
        end else if (full) begin
          if (out_ld) state_nxt = dotr_pkg::ST_IDLE;
        end else if (start_r == now_r) begin
          state_nxt = dotr_pkg::ST_HEAD;
        end else begin
          state_nxt = dotr_pkg::ST_IDLE;
        end
      end
      dotr_pkg::ST_HEAD: begin
        if (out_ld) state_nxt = dotr_pkg::ST_IDLE;
      end
      default: state_nxt = dotr_pkg::ST_IDLE;
    endcase
  end

  // chain commands, results and fill count
  always_comb begin
    ctl.cmd        = dotr_pkg::CMD_HOLD;
    ctl.ins_handle = handle_r;
    count_nxt      = count_r;
    emit           = 1'b0;
    e_handle       = head_handle;
    e_kind         = dotr_pkg::KIND_DUE;
    e_last         = 1'b1;
    case (state_r)
      dotr_pkg::ST_PAST: begin
        emit     = out_ld;
        e_handle = handle_r;
      end
      dotr_pkg::ST_DRAIN: begin
        if (head_due) begin
          if (out_ld) begin
            emit      = 1'b1;
            ctl.cmd   = dotr_pkg::CMD_SHIFT;
            count_nxt = count_r - CW'(1);
            // after the last due entry a schedule due on arrival still yields its own due release
            if (op_r == dotr_pkg::OP_TICK) begin
              e_last = !next_due;
            end else begin
              e_last = !next_due && (start_r != now_r);
            end
          end
        end else if (op_r == dotr_pkg::OP_SCHEDULE) begin
          if (full) begin
            emit     = out_ld;
            e_handle = handle_r;
            e_kind   = dotr_pkg::KIND_REJECT;
          end else begin
            ctl.cmd   = dotr_pkg::CMD_INSERT;
            count_nxt = count_r + CW'(1);
          end
        end
      end
      dotr_pkg::ST_HEAD: begin
        if (out_ld) begin
          emit      = 1'b1;
          ctl.cmd   = dotr_pkg::CMD_SHIFT;
          count_nxt = count_r - CW'(1);
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dotr_pkg::ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (emit) begin
      out_handle_r <= e_handle;
      out_kind_r   <= e_kind;
      out_last_r   <= e_last;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_released_handle = out_handle_r;
  assign out_result_kind     = out_kind_r;
  assign out_last            = out_last_r;

endmodule

/* rtl/core/dotr_cell.sv */
// one cell of the sorted chain: holds a time and a handle
module dotr_cell #(
  parameter int TW = 48
) (
  input  logic                             clk,
  input  dotr_pkg::cell_ctl_t              ctl,
  input  logic [TW-1:0]                    ins_time,
  input  logic                             occ,
  input  logic                             prev_keep,
  input  logic [TW-1:0]                    left_time,
  input  logic [dotr_pkg::HANDLE_BITS-1:0] left_handle,
  input  logic [TW-1:0]                    right_time,
  input  logic [dotr_pkg::HANDLE_BITS-1:0] right_handle,
  output logic                             keep,
  output logic [TW-1:0]                    time_q,
  output logic [dotr_pkg::HANDLE_BITS-1:0] handle_q
);

  logic [TW-1:0]                    time_r, time_nxt;
  logic [dotr_pkg::HANDLE_BITS-1:0] handle_r, handle_nxt;

  // an occupied entry at or before the new time stays in place (stable ties)
  assign keep = occ && (time_r <= ins_time);

  // next contents: hold, take new entry, take from left, or take from right
  always_comb begin
    time_nxt   = time_r;
    handle_nxt = handle_r;
    case (ctl.cmd)
      dotr_pkg::CMD_INSERT: begin
        if (!keep) begin
          if (prev_keep) begin
            time_nxt   = ins_time;
            handle_nxt = ctl.ins_handle;
          end else begin
            time_nxt   = left_time;
            handle_nxt = left_handle;
          end
        end
      end
      dotr_pkg::CMD_SHIFT: begin
        time_nxt   = right_time;
        handle_nxt = right_handle;
      end
      default: begin
        time_nxt   = time_r;
        handle_nxt = handle_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    time_r   <= time_nxt;
    handle_r <= handle_nxt;
  end

  assign time_q   = time_r;
  assign handle_q = handle_r;

endmodule

/* rtl/core/dotr_chain.sv */
// row of cells kept in start-time order, head at cell 0
module dotr_chain #(
  parameter int DEPTH = 16,
  parameter int TW    = 48,
  parameter int CW    = 5
) (
  input  logic                             clk,
  input  dotr_pkg::cell_ctl_t              ctl,
  input  logic [TW-1:0]                    ins_time,
  input  logic [CW-1:0]                    count,
  output logic [TW-1:0]                    head_time,
  output logic [dotr_pkg::HANDLE_BITS-1:0] head_handle,
  output logic [TW-1:0]                    next_time
);

  logic [TW-1:0]                    t_q [DEPTH];
  logic [dotr_pkg::HANDLE_BITS-1:0] h_q [DEPTH];
  logic [DEPTH-1:0]                 keep_q;

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      logic                             occ;
      logic                             prev_keep;
      logic [TW-1:0]                    lt, rt;
      logic [dotr_pkg::HANDLE_BITS-1:0] lh, rh;

      // cell is occupied when it lies below the fill count
      assign occ = CW'(i) < count;

      // neighbor wiring, zero data at the ends; cell 0 sees its left neighbor as kept
      if (i == 0) begin : g_first
        assign prev_keep = 1'b1;
        assign lt = '0;
        assign lh = '0;
      end else begin : g_mid
        assign prev_keep = keep_q[i-1];
        assign lt = t_q[i-1];
        assign lh = h_q[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
        assign rt = '0;
        assign rh = '0;
      end else begin : g_inner
        assign rt = t_q[i+1];
        assign rh = h_q[i+1];
      end

      dotr_cell #(.TW(TW)) u_cell (
        .clk          (clk),
        .ctl          (ctl),
        .ins_time     (ins_time),
        .occ          (occ),
        .prev_keep    (prev_keep),
        .left_time    (lt),
        .left_handle  (lh),
        .right_time   (rt),
        .right_handle (rh),
        .keep         (keep_q[i]),
        .time_q       (t_q[i]),
        .handle_q     (h_q[i])
      );
    end
  endgenerate

  assign head_time   = t_q[0];
  assign head_handle = h_q[0];
  assign next_time   = t_q[1];

endmodule

/* tb/tb_deadline_ordered_task_release.sv */
`timescale 1ns / 1ps
// self-checking testbench for deadline_ordered_task_release with a release predictor
module tb_deadline_ordered_task_release;

  localparam int          STORE_DEPTH  = 16;
  localparam int          TIME_W       = 48;
  localparam logic [47:0] TIME_MAX     = '1;
  localparam logic [2:0]  HALTED_ADDR  = {dotr_pkg::REG_HALTED, 2'b00};
  localparam int          DRAIN_CYCLES = 40;
  localparam int          RANDOM_ITEMS = 330;
  localparam int          HALTED_ITEMS = 30;

  // one expected result transaction
  typedef struct packed {
    logic [dotr_pkg::HANDLE_BITS-1:0] handle;
    logic                             kind;
    logic                             last;
  } release_t;

  // receiver stall patterns
  typedef enum int {FLOW_FREE, FLOW_LIGHT, FLOW_HALF, FLOW_HEAVY} flow_t;

  // predicts releases and rejects, holds them until the block delivers them
  class release_tracker;
    logic [47:0]                      held_times[$];
    logic [dotr_pkg::HANDLE_BITS-1:0] held_handles[$];
    bit                               halted = 1'b0;
    release_t                         due_releases[$];
    int failures = 0;
    int accepted = 0;
    int ignored = 0;
    int released = 0;
    int immediate = 0;
    int rejected = 0;
    int peak_held = 0;

    function void flag(string msg);
      failures++;
      if (failures <= 10)
        $display("[%0t] %s", $time, msg);
    endfunction

    function void queue_release(logic [dotr_pkg::HANDLE_BITS-1:0] h, logic kind);
      release_t r;
      r.handle = h;
      r.kind   = kind;
      r.last   = 1'b0;
      due_releases.push_back(r);
      if (kind == dotr_pkg::KIND_DUE) released++;
      else rejected++;
    endfunction

    // pop every held entry whose time has come, earliest first
    function void pop_due(logic [47:0] now);
      while (held_times.size() > 0 && held_times[0] <= now) begin
        queue_release(held_handles[0], dotr_pkg::KIND_DUE);
        void'(held_times.pop_front());
        void'(held_handles.pop_front());
      end
    endfunction

    function void note_request(logic op, logic [dotr_pkg::HANDLE_BITS-1:0] h,
                               logic [47:0] start_t, logic [47:0] now);
      int       n_prior;
      int       pos;
      release_t tail;
      accepted++;
      if (halted) begin
        ignored++;
        return;
      end
      n_prior = due_releases.size();
      if (op == dotr_pkg::OP_SCHEDULE) begin
        if (start_t < now) begin
          queue_release(h, dotr_pkg::KIND_DUE);
          immediate++;
        end else begin
          pop_due(now);
          if (held_times.size() >= STORE_DEPTH) begin
            queue_release(h, dotr_pkg::KIND_REJECT);
          end else begin
            // stable insert: after every entry with an equal or earlier time
            pos = 0;
            while (pos < held_times.size() && held_times[pos] <= start_t) pos++;
            held_times.insert(pos, start_t);
            held_handles.insert(pos, h);
            if (held_times.size() > peak_held) peak_held = held_times.size();
            pop_due(now);
          end
        end
      end else begin
        pop_due(now);
      end
      // mark the final result of this transaction
      if (due_releases.size() > n_prior) begin
        tail = due_releases.pop_back();
        tail.last = 1'b1;
        due_releases.push_back(tail);
      end
    endfunction

    function void check_release(logic [dotr_pkg::HANDLE_BITS-1:0] h, logic kind, logic last);
      release_t want;
      if (due_releases.size() == 0) begin
        flag($sformatf("unexpected result: handle %h kind %0d last %0d", h, kind, last));
        return;
      end
      want = due_releases.pop_front();
      if (want.handle !== h || want.kind !== kind || want.last !== last)
        flag($sformatf({"result mismatch: expected handle %h kind %0d last %0d, ",
                        "got handle %h kind %0d last %0d"},
                       want.handle, want.kind, want.last, h, kind, last));
    endfunction
  endclass

  logic                             clk             = 1'b0;
  logic                             rst_n           = 1'b0;
  logic                             in_valid        = 1'b0;
  logic                             in_operation    = dotr_pkg::OP_SCHEDULE;
  logic [dotr_pkg::HANDLE_BITS-1:0] in_task_handle  = '0;
  logic [47:0]                      in_start_time   = '0;
  logic [47:0]                      in_current_time = '0;
  logic                             out_stall       = 1'b0;
  logic                             psel            = 1'b0;
  logic                             penable         = 1'b0;
  logic                             pwrite          = 1'b0;
  logic [2:0]                       paddr           = '0;
  logic [31:0]                      pwdata          = '0;
  logic                             in_stall;
  logic                             out_valid;
  logic [dotr_pkg::HANDLE_BITS-1:0] out_released_handle;
  logic                             out_result_kind;
  logic                             out_last;
  logic [31:0]                      prdata;
  logic                             pready;

  release_tracker board = new();

  // stimulus state
  logic [47:0] now_ticks = '0;
  int          burst_left = 0;
  int          seg_left = 0;
  int          adv_max = 0;
  int          span = 8;
  flow_t       flow_mode = FLOW_FREE;
  int          flow_run = 0;

  deadline_ordered_task_release #(
    .QUEUE_DEPTH(STORE_DEPTH),
    .TIME_BITS  (TIME_W)
  ) uut (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  // run limit
  initial begin
    #4_000_000;
    $display("deadline_ordered_task_release test failed");
    $finish;
  end

  // receiver stall pattern, switching between styles
  always @(posedge clk) begin
    if (flow_run == 0) begin
      flow_mode <= flow_t'($urandom_range(0, 3));
      flow_run  <= $urandom_range(10, 120);
    end else begin
      flow_run <= flow_run - 1;
    end
    case (flow_mode)
      FLOW_FREE:  out_stall <= 1'b0;
      FLOW_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      FLOW_HALF:  out_stall <= ($urandom_range(0, 1) == 0);
      default:    out_stall <= ($urandom_range(0, 9) < 8);
    endcase
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_release(out_released_handle, out_result_kind, out_last);
  end

  // present one transaction and hold it until accepted
  task automatic send_item(logic op, logic [dotr_pkg::HANDLE_BITS-1:0] h,
                           logic [47:0] start_t, logic [47:0] now);
    in_valid        <= 1'b1;
    in_operation    <= op;
    in_task_handle  <= h;
    in_start_time   <= start_t;
    in_current_time <= now;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_request(op, h, start_t, now);
  endtask

  // sender in bursts with random gaps between them
  task automatic paced_send(logic op, logic [dotr_pkg::HANDLE_BITS-1:0] h,
                            logic [47:0] start_t, logic [47:0] now);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? 64 : $urandom_range(1, 16);
    end
    burst_left--;
    send_item(op, h, start_t, now);
  endtask

  // stop sending and let every expected result arrive, then let the block go quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (board.due_releases.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // write the halted register and read it back
  task automatic set_halted(logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= HALTED_ADDR;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    board.halted = value[0];
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[0] !== board.halted)
      board.flag($sformatf("halted readback: expected %0d, got %0d",
                           board.halted, prdata[0]));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // pick pacing of time and spread of start times, sometimes jump time forward
  task automatic start_segment();
    logic [63:0] room;
    logic [63:0] jump;
    case ($urandom_range(0, 2))
      0:       adv_max = 0;
      1:       adv_max = 2;
      default: adv_max = 16;
    endcase
    case ($urandom_range(0, 2))
      0:       span = 8;
      1:       span = 64;
      default: span = 5000;
    endcase
    seg_left = $urandom_range(15, 45);
    if ($urandom_range(0, 2) == 0) begin
      room = 64'(TIME_MAX) - 64'(now_ticks);
      jump = {$urandom, $urandom} % (room / 4 + 1);
      now_ticks = now_ticks + jump[47:0];
    end
  endtask

  task automatic send_random();
    logic                             op;
    logic [dotr_pkg::HANDLE_BITS-1:0] h;
    logic [47:0]                      start_t;
    logic [63:0]                      sum;
    int                               pick;
    int                               d;
    if (seg_left == 0) start_segment();
    seg_left--;
    op   = ($urandom_range(0, 4) == 0) ? dotr_pkg::OP_TICK : dotr_pkg::OP_SCHEDULE;
    h    = 16'($urandom_range(0, 65535));
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      d = $urandom_range(1, span);
      start_t = (now_ticks >= 48'(d)) ? now_ticks - 48'(d) : '0;
    end else if (pick < 24) begin
      start_t = now_ticks;
    end else if (pick < 96) begin
      sum = 64'(now_ticks) + 64'($urandom_range(1, span));
      start_t = (sum > 64'(TIME_MAX)) ? TIME_MAX : sum[47:0];
    end else begin
      start_t = {16'($urandom), $urandom};
    end
    paced_send(op, h, start_t, now_ticks);
    sum = 64'(now_ticks) + 64'($urandom_range(0, adv_max));
    now_ticks = (sum > 64'(TIME_MAX)) ? TIME_MAX : sum[47:0];
  endtask

  initial begin
    int wait_cycles;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // clear halt with every upper data bit set
    set_halted(32'hFFFF_FFFE);

    // directed opening
    paced_send(dotr_pkg::OP_TICK, 16'h1234, TIME_MAX, 48'd0);       // tick on empty store
    paced_send(dotr_pkg::OP_SCHEDULE, 16'h0000, 48'd0, 48'd0);      // due on arrival
    paced_send(dotr_pkg::OP_SCHEDULE, 16'hFFFF, TIME_MAX, 48'd0);   // latest possible time
    paced_send(dotr_pkg::OP_SCHEDULE, 16'h00A5, 48'd3, 48'd7);      // already past
    // fill the store, pairs of equal times check arrival order
    for (int i = 0; i < STORE_DEPTH - 1; i++)
      paced_send(dotr_pkg::OP_SCHEDULE, 16'(16'h0100 + i), 48'(100 + i / 2), 48'd10);
    paced_send(dotr_pkg::OP_SCHEDULE, 16'hAAAA, 48'd200, 48'd10);   // full, nothing due
    paced_send(dotr_pkg::OP_SCHEDULE, 16'h5555, 48'd150, 48'd101);  // due entries free room
    paced_send(dotr_pkg::OP_TICK, 16'h0000, 48'd0, 48'd101);        // tick with nothing due
    now_ticks = 48'd101;

    // random traffic, first half
    for (int i = 0; i < RANDOM_ITEMS / 2; i++) send_random();

    // halted phase: all traffic ignored
    settle();
    set_halted(32'hFFFF_FFFF);
    for (int i = 0; i < HALTED_ITEMS; i++) send_random();
    settle();
    set_halted(32'h0000_0000);

    // random traffic, second half
    for (int i = RANDOM_ITEMS / 2; i < RANDOM_ITEMS; i++) send_random();

    // closing: release everything at the end of time, then a due-on-arrival at the top
    paced_send(dotr_pkg::OP_TICK, 16'h0000, 48'd0, TIME_MAX);
    paced_send(dotr_pkg::OP_SCHEDULE, 16'hFFFF, TIME_MAX, TIME_MAX);

    // drain
    in_valid <= 1'b0;
    wait_cycles = 0;
    while (board.due_releases.size() != 0 && wait_cycles < 20000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.due_releases.size() != 0)
      board.flag($sformatf("%0d expected results never arrived", board.due_releases.size()));

    $display("covered %0d transactions (%0d ignored while halted): %0d due releases,",
             board.accepted, board.ignored, board.released);
    $display("%0d of them past start, %0d rejects; store held up to %0d of %0d entries",
             board.immediate, board.rejected, board.peak_held, STORE_DEPTH);
    if (board.failures == 0)
      $display("deadline_ordered_task_release test passed");
    else
      $display("deadline_ordered_task_release test failed");
    $finish;
  end

endmodule
